### src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/stq_pkg.sv
// Package for the shell quote tokenizer: item types, character codes, queue sizing.
`default_nettype none

package stq_pkg;

    localparam logic [7:0] BSL = 8'h5C;
    localparam logic [7:0] SQ  = 8'h27;
    localparam logic [7:0] DQ  = 8'h22;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       word_end;
        logic       line_done;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       word_end;
        logic       line_done;
    } res_t;

    // One classified item: one result, or a pair when pair is set.
    typedef struct packed {
        logic pair;
        res_t r0;
        res_t r1;
    } cmd_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    endfunction

endpackage

`default_nettype wire

### src/stq_front.sv
// Front end: takes input items, tracks quote/escape/word state, classifies into commands.
`default_nettype none

module stq_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire stq_pkg::in_item_t item,
    input  wire logic             q_full,
    output logic                  q_wr,
    output stq_pkg::cmd_t         q_data
);

    logic [1:0] mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic       open_reg, open_next;
    logic       emit;
    logic       accept;
    logic [7:0] c;

    assign c      = item.ch;
    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_wr   = accept && emit;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        open_next = open_reg;
        q_data    = '0;
        emit      = 1'b0;
        if (item.kind)
        begin
            // end of line: close an open word, then mark the line done
            emit = 1'b1;
            if (open_reg)
            begin
                q_data.pair        = 1'b1;
                q_data.r0.word_end = 1'b1;
                q_data.r1.line_done = 1'b1;
            end
            else
            begin
                q_data.r0.line_done = 1'b1;
            end
            mode_next = stq_pkg::MODE_NONE;
            esc_next  = 1'b0;
            open_next = 1'b0;
        end
        else if (esc_reg)
        begin
            emit = 1'b1;
            if (mode_reg == stq_pkg::MODE_DOUBLE && c != stq_pkg::DQ && c != stq_pkg::BSL)
            begin
                q_data.pair        = 1'b1;
                q_data.r0.out_byte = stq_pkg::BSL;
                q_data.r1.out_byte = c;
            end
            else
            begin
                q_data.r0.out_byte = c;
            end
            open_next = 1'b1;
            esc_next  = 1'b0;
        end
        else if (mode_reg == stq_pkg::MODE_SINGLE)
        begin
            if (c == stq_pkg::SQ)
            begin
                mode_next = stq_pkg::MODE_NONE;
            end
            else
            begin
                emit               = 1'b1;
                q_data.r0.out_byte = c;
                open_next          = 1'b1;
            end
        end
        else if (mode_reg == stq_pkg::MODE_DOUBLE)
        begin
            if (c == stq_pkg::BSL)
            begin
                esc_next = 1'b1;
            end
            else if (c == stq_pkg::DQ)
            begin
                mode_next = stq_pkg::MODE_NONE;
            end
            else
            begin
                emit               = 1'b1;
                q_data.r0.out_byte = c;
                open_next          = 1'b1;
            end
        end
        else
        begin
            if (c == stq_pkg::BSL)
            begin
                esc_next = 1'b1;
            end
            else if (c == stq_pkg::SQ)
            begin
                mode_next = stq_pkg::MODE_SINGLE;
            end
            else if (c == stq_pkg::DQ)
            begin
                mode_next = stq_pkg::MODE_DOUBLE;
            end
            else if (stq_pkg::is_space(c))
            begin
                emit               = open_reg;
                q_data.r0.word_end = 1'b1;
                open_next          = 1'b0;
            end
            else
            begin
                emit               = 1'b1;
                q_data.r0.out_byte = c;
                open_next          = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= stq_pkg::MODE_NONE;
            esc_reg  <= 1'b0;
            open_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            open_reg <= open_next;
        end
    end

endmodule

`default_nettype wire

### src/stq_queue.sv
// Short command queue between front and back ends.
`default_nettype none

module stq_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire stq_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output stq_pkg::cmd_t      rd_data,
    output logic               empty
);

    stq_pkg::cmd_t                 mem_reg [stq_pkg::QDEPTH];
    logic [stq_pkg::QAW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [stq_pkg::QCW-1:0]       count_reg, count_next;
    logic                          do_wr, do_rd;

    assign full    = (count_reg == stq_pkg::QCW'(stq_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/stq_back.sv
// Back end: expands commands into one or two results and holds them in the output register.
`default_nettype none

module stq_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire stq_pkg::cmd_t head,
    input  wire logic          q_empty,
    output logic               q_rd,
    output logic               empty,
    input  wire logic          pop,
    output stq_pkg::out_item_t result
);

    logic               valid_reg, valid_next;
    logic               sub_reg, sub_next;
    stq_pkg::out_item_t result_reg;
    stq_pkg::res_t      sel;
    logic               load;
    logic               last_flag;

    assign empty     = !valid_reg;
    assign result    = result_reg;
    assign load      = (!valid_reg || pop) && !q_empty;
    assign sel       = sub_reg ? head.r1 : head.r0;
    assign last_flag = !(head.pair && !sub_reg);
    // retire the queue entry only once its final result is loaded
    assign q_rd      = load && last_flag;

    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = !last_flag;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= {sel.out_byte, sel.word_end, sel.line_done, last_flag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

endmodule

`default_nettype wire

### src/shell_quote_tokenizer.sv
// Top level of the shell quote tokenizer: front end, command queue, back end.
//
//   channel | handshake        | payload
//   --------+------------------+--------------------------------------------
//   item    | push / full      | in_item_t: kind, ch
//   result  | empty / pop      | out_item_t: out_byte, word_end, line_done, last
//
// One item is taken per cycle while the queue has room; its first result goes through the
// queue register and then into the output register, once that register is free.
// An item with two results (word close at end of line, kept backslash in double quotes)
// fills the output register twice before its queue entry is retired.
// full rises only when the queue holds four commands; items with no result take no slot but wait while it is full.
// Reset clears quote mode, escape and word flags, the queue and the output valid flag.
`default_nettype none

module shell_quote_tokenizer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire stq_pkg::in_item_t item,
    output logic                   empty,
    input  wire logic              pop,
    output stq_pkg::out_item_t     result
);

    stq_pkg::cmd_t wr_cmd, head_cmd;
    logic          q_wr, q_rd, q_full, q_empty;

    stq_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_data (wr_cmd)
    );

    stq_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (wr_cmd),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (head_cmd),
        .empty   (q_empty)
    );

    stq_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head_cmd),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

### src/stq_checker.sv
// Port-level checker for the shell quote tokenizer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module stq_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire stq_pkg::out_item_t result
);

    `ASSERT_CLK(a_hold, (!empty && !pop) |=> (!empty && $stable(result)), "result changed while waiting")
    `ASSERT_NEVER(a_marks, !empty && result.word_end && result.line_done, "word_end with line_done")
    `ASSERT_CLK(a_done_last, (!empty && result.line_done) |-> result.last, "line_done not last")
    `ASSERT_CLK(a_eol_pair, (pop && !empty && result.word_end && !result.last) |=> (!empty && result.line_done), "word close at end of line not followed by line_done")

endmodule

bind shell_quote_tokenizer stq_checker u_stq_checker (.*);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the shell quote tokenizer: directed and random command lines.
`default_nettype none

module tb_top;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam int MAX_GAP     = 12;
    localparam int DRAIN_TAIL  = 6;
    localparam int RANDOM_ITEMS = 1100;
    localparam int NOISE_ITEMS  = 330;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               push  = 1'b0;
    logic               pop   = 1'b0;
    logic               full;
    logic               empty;
    stq_pkg::in_item_t  item  = '0;
    stq_pkg::out_item_t result;

    // tokenizer state mirrored by the bench
    logic [1:0] q_mode    = stq_pkg::MODE_NONE;
    logic       esc_armed = 1'b0;
    logic       in_word   = 1'b0;

    stq_pkg::out_item_t expected_tokens[$];
    int                 errors      = 0;
    int                 items_sent  = 0;
    bit                 send_idle   = 1'b1;
    bit                 recv_idle   = 1'b1;
    int                 hold_cycles = 0;

    shell_quote_tokenizer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #4 clk = ~clk;

    function automatic logic is_blank(logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic stq_pkg::out_item_t make_token(logic [7:0] b, logic we, logic ld);
        stq_pkg::out_item_t t;
        t.out_byte  = b;
        t.word_end  = we;
        t.line_done = ld;
        t.last      = 1'b0;
        return t;
    endfunction

    function automatic void tokenize_item(stq_pkg::in_item_t it);
        stq_pkg::out_item_t toks[$];
        if (it.kind == KIND_EOL)
        begin
            if (in_word)
                toks.insert(toks.size(), make_token(8'h00, 1'b1, 1'b0));
            toks.insert(toks.size(), make_token(8'h00, 1'b0, 1'b1));
            q_mode    = stq_pkg::MODE_NONE;
            esc_armed = 1'b0;
            in_word   = 1'b0;
        end
        else if (esc_armed)
        begin
            if (q_mode == stq_pkg::MODE_DOUBLE && it.ch != stq_pkg::DQ && it.ch != stq_pkg::BSL)
                toks.insert(toks.size(), make_token(stq_pkg::BSL, 1'b0, 1'b0));
            toks.insert(toks.size(), make_token(it.ch, 1'b0, 1'b0));
            in_word   = 1'b1;
            esc_armed = 1'b0;
        end
        else if (q_mode == stq_pkg::MODE_SINGLE)
        begin
            if (it.ch == stq_pkg::SQ)
                q_mode = stq_pkg::MODE_NONE;
            else
            begin
                toks.insert(toks.size(), make_token(it.ch, 1'b0, 1'b0));
                in_word = 1'b1;
            end
        end
        else if (q_mode == stq_pkg::MODE_DOUBLE)
        begin
            if (it.ch == stq_pkg::BSL)
                esc_armed = 1'b1;
            else if (it.ch == stq_pkg::DQ)
                q_mode = stq_pkg::MODE_NONE;
            else
            begin
                toks.insert(toks.size(), make_token(it.ch, 1'b0, 1'b0));
                in_word = 1'b1;
            end
        end
        else
        begin
            // unquoted; an impossible mode 3 behaves the same way
            if (it.ch == stq_pkg::BSL)
                esc_armed = 1'b1;
            else if (it.ch == stq_pkg::SQ)
                q_mode = stq_pkg::MODE_SINGLE;
            else if (it.ch == stq_pkg::DQ)
                q_mode = stq_pkg::MODE_DOUBLE;
            else if (is_blank(it.ch))
            begin
                if (in_word)
                    toks.insert(toks.size(), make_token(8'h00, 1'b1, 1'b0));
                in_word = 1'b0;
            end
            else
            begin
                toks.insert(toks.size(), make_token(it.ch, 1'b0, 1'b0));
                in_word = 1'b1;
            end
        end
        if (toks.size() > 0)
            toks[toks.size() - 1].last = 1'b1;
        foreach (toks[i])
            expected_tokens.insert(expected_tokens.size(), toks[i]);
    endfunction

    function automatic void check_token(stq_pkg::out_item_t got);
        stq_pkg::out_item_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("unexpected result: out_byte %02h word_end %0b line_done %0b last %0b",
                   got.out_byte, got.word_end, got.line_done, got.last);
            errors++;
            return;
        end
        want = expected_tokens.pop_front();
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            errors++;
        end
        if (got.word_end !== want.word_end)
        begin
            $error("word_end: expected %0b, got %0b", want.word_end, got.word_end);
            errors++;
        end
        if (got.line_done !== want.line_done)
        begin
            $error("line_done: expected %0b, got %0b", want.line_done, got.line_done);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
        end
    endfunction

    // Keep push high on exit so a back-to-back item needs no second assignment.
    task automatic send_item(stq_pkg::in_item_t it);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tokenize_item(it);
        items_sent++;
    endtask

    task automatic send_char(logic [7:0] c);
        stq_pkg::in_item_t it;
        it.kind = KIND_CHAR;
        it.ch   = c;
        send_item(it);
    endtask

    task automatic send_eol();
        stq_pkg::in_item_t it;
        it.kind = KIND_EOL;
        it.ch   = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == stq_pkg::BSL || c == stq_pkg::SQ || c == stq_pkg::DQ || is_blank(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_other(logic [7:0] a, logic [7:0] b);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == a || c == b);
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        logic [7:0] c;
        c = 8'($urandom_range(CH_TAB, CH_CR + 1));
        return (c > CH_CR) ? CH_SPACE : c;
    endfunction

    task automatic send_blanks();
        repeat ($urandom_range(1, 3)) send_char(pick_blank());
    endtask

    task automatic send_segment();
        case ($urandom_range(0, 4))
            0: repeat ($urandom_range(1, 4)) send_char(pick_plain());
            1:
            begin
                send_char(stq_pkg::BSL);
                send_char(8'($urandom_range(0, 255)));
            end
            2:
            begin
                send_char(stq_pkg::SQ);
                repeat ($urandom_range(0, 4)) send_char(pick_other(stq_pkg::SQ, stq_pkg::SQ));
                send_char(stq_pkg::SQ);
            end
            3:
            begin
                send_char(stq_pkg::DQ);
                repeat ($urandom_range(0, 4))
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        send_char(stq_pkg::BSL);
                        case ($urandom_range(0, 3))
                            0: send_char(stq_pkg::DQ);
                            1: send_char(stq_pkg::BSL);
                            default: send_char(8'($urandom_range(0, 255)));
                        endcase
                    end
                    else
                        send_char(pick_other(stq_pkg::DQ, stq_pkg::BSL));
                end
                send_char(stq_pkg::DQ);
            end
            default:
            begin
                // empty quotes
                if ($urandom_range(0, 1) == 0)
                begin
                    send_char(stq_pkg::DQ);
                    send_char(stq_pkg::DQ);
                end
                else
                begin
                    send_char(stq_pkg::SQ);
                    send_char(stq_pkg::SQ);
                end
            end
        endcase
    endtask

    task automatic send_random_line();
        int n_words;
        n_words = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            send_blanks();
        for (int w = 0; w < n_words; w++)
        begin
            repeat ($urandom_range(1, 3)) send_segment();
            if (w != n_words - 1 || $urandom_range(0, 3) == 0)
                send_blanks();
        end
        // broken endings: unclosed quote, dangling escape
        case ($urandom_range(0, 9))
            0:
            begin
                send_char(stq_pkg::SQ);
                send_char(pick_plain());
            end
            1: send_char(stq_pkg::BSL);
            2:
            begin
                send_char(stq_pkg::DQ);
                send_char(pick_plain());
                send_char(stq_pkg::BSL);
            end
            default: ;
        endcase
        send_eol();
    endtask

    task automatic test_word_splitting();
        send_char("a");
        send_char(8'hFF);
        send_char(CH_TAB);
        send_char(CH_SPACE);
        send_char(stq_pkg::DQ);
        send_char(stq_pkg::DQ);
        send_char(CH_CR);
        send_char(8'h00);
        send_char(8'd14);
        send_char(8'd8);
        wait_drained();
    endtask

    task automatic test_quoting();
        send_char(stq_pkg::SQ);
        send_char(stq_pkg::BSL);
        send_char(CH_SPACE);
        send_char(stq_pkg::SQ);
        send_char(stq_pkg::DQ);
        send_char(stq_pkg::BSL);
        send_char("n");
        send_char(stq_pkg::BSL);
        send_char(stq_pkg::DQ);
        send_char(stq_pkg::BSL);
        send_char(stq_pkg::BSL);
        send_char(stq_pkg::DQ);
        send_char(stq_pkg::BSL);
        send_char(stq_pkg::SQ);
        wait_drained();
    endtask

    task automatic test_line_end();
        stq_pkg::in_item_t it;
        it.kind = KIND_EOL;
        it.ch   = 8'hFF;
        send_item(it);
        send_char(stq_pkg::BSL);
        send_eol();
        send_char(stq_pkg::DQ);
        send_char("q");
        send_eol();
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle   = 1'b0;
        hold_cycles = 80;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 7 == 6)
                send_char(CH_SPACE);
            else
                send_char(pick_plain());
        end
        send_eol();
        wait_drained();
        send_idle = 1'b1;
    endtask

    task automatic test_random_lines();
        while (items_sent < RANDOM_ITEMS)
        begin
            send_idle = ($urandom_range(0, 3) != 0);
            send_random_line();
        end
        wait_drained();
    endtask

    task automatic test_noise();
        int r;
        repeat (NOISE_ITEMS)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_eol();
            else if (r < 7)
            begin
                case ($urandom_range(0, 3))
                    0: send_char(stq_pkg::BSL);
                    1: send_char(stq_pkg::SQ);
                    2: send_char(stq_pkg::DQ);
                    default: send_char(pick_blank());
                endcase
            end
            else
                send_char(8'($urandom_range(0, 255)));
        end
        send_eol();
        wait_drained();
    endtask

    // receiver: pop with random gaps, honor a requested long hold
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_idle = ~recv_idle;
            gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            check_token(result);
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_word_splitting();
        test_quoting();
        test_line_end();
        test_backpressure();
        test_random_lines();
        test_noise();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
